>>> hdl/cfgp_pkg.sv
// package for the codon frameshift gap padder
// holds sizes, the codon constant and the word group passed from step to emit stage
`timescale 1ns / 1ps

package cfgp_pkg;

   localparam int MAX_COLUMNS = 65536;
   localparam int CODON_LEN   = 3;
   localparam int POS_W       = $clog2(MAX_COLUMNS);
   localparam int POSX_W      = POS_W + 1;
   localparam int RUN_W       = 16;
   localparam int CODE_W      = 4;
   localparam int CODON_W     = 15;
   localparam int OUT_W       = 16;

   localparam logic [RUN_W-1:0]  SAT_MAX   = {RUN_W{1'b1}};
   localparam logic [POSX_W-1:0] MAX_POS_X = POSX_W'(MAX_COLUMNS);
   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(MAX_COLUMNS - 1);
   localparam logic [1:0]        CODON_2   = 2'(CODON_LEN);
   localparam logic [CODE_W-1:0] GAP_RESET = 4'd15;

   typedef struct packed {
      logic [CODE_W-1:0]  ref_base;
      logic [CODE_W-1:0]  query_base;
      logic [CODE_W-1:0]  gap_code;
      logic [1:0]         npad;
      logic [POS_W-1:0]   pos;
      logic               mark;
      logic [CODON_W-1:0] codon;
      logic [OUT_W-1:0]   shift;
      logic               final_col;
      logic [OUT_W-1:0]   trimmed;
   } group_type;

   function automatic logic [1:0] mod3_inc(input logic [1:0] m);
      logic [1:0] r;
      r = (m == CODON_2 - 2'd1) ? 2'd0 : m + 2'd1;
      return r;
   endfunction

endpackage

>>> hdl/codon_frameshift_gap_padder.sv
// top level of the codon frameshift gap padder
// depends on cfgp_pkg, cfgp_step and cfgp_emit
//
// Usage:
//   req_* takes one alignment column per word (reference code, query code,
//   final-column flag). rsp_* gives one to three words per column: the
//   padding columns that close a reference gap run to a whole codon, then
//   the column itself. csr_gap_code sets the code that means a gap; write it
//   only while the block is idle. csr_ready is always high.
//   The first word of a column passes through the input register, then the
//   result register, before it shows on rsp_*. Throughput: while rsp_ready
//   is high the result register sends one word per cycle, padding words
//   first; with no padding a column is then taken every cycle. The input
//   register can still take one column while a finished word waits in the
//   result register.
//   When rsp_ready is low the result word holds, and after the input
//   register fills req_ready drops until the result register frees.
//   Reset clears all column state and sets the gap code to 15. A final
//   column returns the state to reset for the next region.
`timescale 1ns / 1ps

module codon_frameshift_gap_padder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cfgp_pkg::CODE_W-1:0]  req_ref_base,
   input  logic [cfgp_pkg::CODE_W-1:0]  req_query_base,
   input  logic                         req_final_column,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cfgp_pkg::CODE_W-1:0]  rsp_out_ref_base,
   output logic [cfgp_pkg::CODE_W-1:0]  rsp_out_query_base,
   output logic [cfgp_pkg::OUT_W-1:0]   rsp_column_position,
   output logic                         rsp_is_padding,
   output logic                         rsp_misaligned_mark,
   output logic [cfgp_pkg::CODON_W-1:0] rsp_misaligned_codon,
   output logic [cfgp_pkg::OUT_W-1:0]   rsp_frameshift_count,
   output logic [cfgp_pkg::OUT_W-1:0]   rsp_trimmed_length,
   output logic                         rsp_final_result,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [cfgp_pkg::CODE_W-1:0]  csr_gap_code
);
   import cfgp_pkg::*;

   logic [CODE_W-1:0] gap_ff, gap_in;
   logic              grp_valid;
   logic              grp_ready;
   group_type         grp;

   assign csr_ready = 1'b1;
   assign gap_in    = (csr_valid && csr_ready) ? csr_gap_code : gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else begin
         gap_ff <= gap_in;
      end
   end

   cfgp_step u_step (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ref_base     (req_ref_base),
      .req_query_base   (req_query_base),
      .req_final_column (req_final_column),
      .gap_code         (gap_ff),
      .grp_ready        (grp_ready),
      .grp_valid        (grp_valid),
      .grp              (grp)
   );

   cfgp_emit u_emit (
      .clock                (clock),
      .reset                (reset),
      .grp_valid            (grp_valid),
      .grp_ready            (grp_ready),
      .grp                  (grp),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_ref_base     (rsp_out_ref_base),
      .rsp_out_query_base   (rsp_out_query_base),
      .rsp_column_position  (rsp_column_position),
      .rsp_is_padding       (rsp_is_padding),
      .rsp_misaligned_mark  (rsp_misaligned_mark),
      .rsp_misaligned_codon (rsp_misaligned_codon),
      .rsp_frameshift_count (rsp_frameshift_count),
      .rsp_trimmed_length   (rsp_trimmed_length),
      .rsp_final_result     (rsp_final_result)
   );

endmodule

>>> hdl/cfgp_step.sv
// input register, column state and per-column padding / frameshift logic
// depends on cfgp_pkg; feeds one word group per column to cfgp_emit
`timescale 1ns / 1ps

module cfgp_step (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cfgp_pkg::CODE_W-1:0] req_ref_base,
   input  logic [cfgp_pkg::CODE_W-1:0] req_query_base,
   input  logic                        req_final_column,
   input  logic [cfgp_pkg::CODE_W-1:0] gap_code,
   input  logic                        grp_ready,
   output logic                        grp_valid,
   output cfgp_pkg::group_type         grp
);
   import cfgp_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [CODE_W-1:0]   rb_ff, qb_ff;
   logic                fin_ff;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [1:0]          pmod_ff, pmod_in;
   logic [POS_W-1:0]    codon_ff, codon_in;
   logic [RUN_W-1:0]    rrun_ff, rrun_in;
   logic [1:0]          rmod_ff, rmod_in;
   logic [RUN_W-1:0]    qrun_ff, qrun_in;
   logic [1:0]          qmod_ff, qmod_in;
   logic [RUN_W-1:0]    shift_ff, shift_in;

   logic                take;
   logic                mark;
   logic [1:0]          npad;
   logic [RUN_W-1:0]    rrun_nx, qrun_nx, shift_nx;
   logic [1:0]          rmod_nx, qmod_nx;
   logic [POSX_W-1:0]   pos_sum;
   logic [POSX_W-1:0]   pos_wrap;
   logic [POS_W-1:0]    pos_after;
   logic [1:0]          pmod_after;
   logic [2:0]          pmod_sum;
   logic [POS_W-1:0]    codon_after;
   logic [POS_W-1:0]    trim_pos;
   logic [POS_W+RUN_W-1:0] qrun_x, pos_x;
   logic [POS_W+OUT_W-1:0] trim_x, codon_x;

   assign take      = in_valid_ff && grp_ready;
   assign req_ready = !in_valid_ff || grp_ready;
   assign grp_valid = in_valid_ff;

   assign qrun_x = {{POS_W{1'b0}}, qrun_ff};
   assign pos_x  = {{RUN_W{1'b0}}, pos_ff};

   always_comb begin
      rrun_nx  = rrun_ff;
      rmod_nx  = rmod_ff;
      qrun_nx  = qrun_ff;
      qmod_nx  = qmod_ff;
      shift_nx = shift_ff;
      mark     = 1'b0;
      npad     = 2'd0;
      if (rb_ff == gap_code) begin
         if (rrun_ff != SAT_MAX) begin
            rrun_nx = rrun_ff + 1'b1;
            rmod_nx = mod3_inc(rmod_ff);
         end
      end else begin
         if (qb_ff == gap_code) begin
            if (qrun_ff != SAT_MAX) begin
               qrun_nx = qrun_ff + 1'b1;
               qmod_nx = mod3_inc(qmod_ff);
            end
         end else if (qmod_ff != 2'd0) begin
            if (qrun_x != pos_x && shift_ff != SAT_MAX) begin
               shift_nx = shift_ff + 1'b1;
            end
            qrun_nx = '0;
            qmod_nx = 2'd0;
         end else if (rrun_ff != '0 && rmod_ff == 2'd0 && pmod_ff != 2'd0) begin
            mark = 1'b1;
         end
         if (rmod_ff != 2'd0 && pmod_ff != rmod_ff) begin
            mark = 1'b1;
         end
         npad    = (rmod_ff == 2'd0) ? 2'd0 : CODON_2 - rmod_ff;
         rrun_nx = '0;
         rmod_nx = 2'd0;
      end
   end

   // position after the 1 to 3 words of this column, with wrap
   always_comb begin
      pos_sum  = {1'b0, pos_ff} + {{(POSX_W-2){1'b0}}, npad} + 1'b1;
      pos_wrap = pos_sum - MAX_POS_X;
      pmod_sum = {1'b0, pmod_ff} + {1'b0, npad} + 3'd1;
      if (pos_sum >= MAX_POS_X) begin
         pos_after   = pos_wrap[POS_W-1:0];
         pmod_after  = pos_wrap[1:0];
         codon_after = '0;
      end else begin
         pos_after = pos_sum[POS_W-1:0];
         if (pmod_sum >= {1'b0, CODON_2}) begin
            pmod_after  = 2'(pmod_sum - {1'b0, CODON_2});
            codon_after = codon_ff + 1'b1;
         end else begin
            pmod_after  = pmod_sum[1:0];
            codon_after = codon_ff;
         end
      end
      trim_pos = pos_after - {{(POS_W-2){1'b0}}, pmod_after};
      trim_x   = {{OUT_W{1'b0}}, trim_pos};
      codon_x  = {{OUT_W{1'b0}}, codon_ff};
   end

   always_comb begin
      grp.ref_base   = rb_ff;
      grp.query_base = qb_ff;
      grp.gap_code   = gap_code;
      grp.npad       = npad;
      grp.pos        = pos_ff;
      grp.mark       = mark;
      grp.codon      = mark ? codon_x[CODON_W-1:0] : '0;
      grp.shift      = shift_nx;
      grp.final_col  = fin_ff;
      grp.trimmed    = fin_ff ? trim_x[OUT_W-1:0] : '0;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      pos_in      = pos_ff;
      pmod_in     = pmod_ff;
      codon_in    = codon_ff;
      rrun_in     = rrun_ff;
      rmod_in     = rmod_ff;
      qrun_in     = qrun_ff;
      qmod_in     = qmod_ff;
      shift_in    = shift_ff;
      if (take) begin
         in_valid_in = 1'b0;
         if (fin_ff) begin
            pos_in   = '0;
            pmod_in  = 2'd0;
            codon_in = '0;
            rrun_in  = '0;
            rmod_in  = 2'd0;
            qrun_in  = '0;
            qmod_in  = 2'd0;
            shift_in = '0;
         end else begin
            pos_in   = pos_after;
            pmod_in  = pmod_after;
            codon_in = codon_after;
            rrun_in  = rrun_nx;
            rmod_in  = rmod_nx;
            qrun_in  = qrun_nx;
            qmod_in  = qmod_nx;
            shift_in = shift_nx;
         end
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         pmod_ff     <= 2'd0;
         codon_ff    <= '0;
         rrun_ff     <= '0;
         rmod_ff     <= 2'd0;
         qrun_ff     <= '0;
         qmod_ff     <= 2'd0;
         shift_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
         pmod_ff     <= pmod_in;
         codon_ff    <= codon_in;
         rrun_ff     <= rrun_in;
         rmod_ff     <= rmod_in;
         qrun_ff     <= qrun_in;
         qmod_ff     <= qmod_in;
         shift_ff    <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rb_ff  <= req_ref_base;
         qb_ff  <= req_query_base;
         fin_ff <= req_final_column;
      end
   end

endmodule

>>> hdl/cfgp_emit.sv
// result register: sends the padding words of a column, then the column word
// depends on cfgp_pkg; loaded from cfgp_step
`timescale 1ns / 1ps

module cfgp_emit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         grp_valid,
   output logic                         grp_ready,
   input  cfgp_pkg::group_type          grp,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cfgp_pkg::CODE_W-1:0]  rsp_out_ref_base,
   output logic [cfgp_pkg::CODE_W-1:0]  rsp_out_query_base,
   output logic [cfgp_pkg::OUT_W-1:0]   rsp_column_position,
   output logic                         rsp_is_padding,
   output logic                         rsp_misaligned_mark,
   output logic [cfgp_pkg::CODON_W-1:0] rsp_misaligned_codon,
   output logic [cfgp_pkg::OUT_W-1:0]   rsp_frameshift_count,
   output logic [cfgp_pkg::OUT_W-1:0]   rsp_trimmed_length,
   output logic                         rsp_final_result
);
   import cfgp_pkg::*;

   logic                   busy_ff, busy_in;
   group_type              grp_ff;
   logic [1:0]             pad_left_ff;
   logic [POS_W-1:0]       pos_ff;
   logic                   last_word;
   logic                   load;
   logic                   advance;
   logic [POS_W+OUT_W-1:0] pos_x;

   assign last_word = (pad_left_ff == 2'd0);
   assign grp_ready = !busy_ff || (last_word && rsp_ready);
   assign load      = grp_valid && grp_ready;
   assign advance   = busy_ff && rsp_ready && !last_word;

   always_comb begin
      busy_in = busy_ff;
      if (busy_ff && rsp_ready && last_word) begin
         busy_in = 1'b0;
      end
      if (load) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff      <= grp;
         pad_left_ff <= grp.npad;
         pos_ff      <= grp.pos;
      end else if (advance) begin
         pad_left_ff <= pad_left_ff - 2'd1;
         pos_ff      <= (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
      end
   end

   assign pos_x = {{OUT_W{1'b0}}, pos_ff};

   always_comb begin
      rsp_valid            = busy_ff;
      rsp_is_padding       = !last_word;
      rsp_out_ref_base     = last_word ? grp_ff.ref_base : grp_ff.gap_code;
      rsp_out_query_base   = last_word ? grp_ff.query_base : grp_ff.gap_code;
      rsp_column_position  = pos_x[OUT_W-1:0];
      rsp_misaligned_mark  = grp_ff.mark;
      rsp_misaligned_codon = grp_ff.codon;
      rsp_frameshift_count = grp_ff.shift;
      rsp_final_result     = grp_ff.final_col && last_word;
      rsp_trimmed_length   = last_word ? grp_ff.trimmed : '0;
   end

endmodule

>>> hdl/cfgp_checker.sv
// port-level checks for the codon frameshift gap padder, bound to the top level
// depends on cfgp_pkg and codon_frameshift_gap_padder
`timescale 1ns / 1ps

module cfgp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [cfgp_pkg::CODE_W-1:0]  rsp_out_ref_base,
   input logic [cfgp_pkg::CODE_W-1:0]  rsp_out_query_base,
   input logic [cfgp_pkg::OUT_W-1:0]   rsp_column_position,
   input logic                         rsp_is_padding,
   input logic                         rsp_misaligned_mark,
   input logic [cfgp_pkg::CODON_W-1:0] rsp_misaligned_codon,
   input logic [cfgp_pkg::OUT_W-1:0]   rsp_trimmed_length,
   input logic                         rsp_final_result
);
   import cfgp_pkg::*;

   // no word shows in the cycle after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column_position)
         && $stable(rsp_is_padding) && $stable(rsp_final_result))
      else $error("stalled result word changed");

   // padding carries the gap code on both sides and never ends a region
   a_pad_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_padding |->
         rsp_out_ref_base == rsp_out_query_base && !rsp_final_result
         && rsp_trimmed_length == '0)
      else $error("bad padding word");

   // codon index only with a mark
   a_codon_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_misaligned_mark |-> rsp_misaligned_codon == '0)
      else $error("codon index without misaligned mark");

endmodule

bind codon_frameshift_gap_padder cfgp_checker u_checker (.*);

>>> dv/codon_frameshift_gap_padder_test.sv
// self-checking test of codon_frameshift_gap_padder: columns in, padded words out
// depends on cfgp_pkg for sizes and codes; predicts every word and checks it in order
`timescale 1ns / 1ps

module codon_frameshift_gap_padder_test;
   import cfgp_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 6;
   localparam int SHOW_LIMIT = 10;

   typedef enum {COL_MATCH, COL_REF_GAP, COL_QRY_GAP, COL_BOTH_GAP} column_kind_type;

   typedef struct packed {
      logic [CODE_W-1:0]  ref_code;
      logic [CODE_W-1:0]  query_code;
      logic [OUT_W-1:0]   position;
      logic               pad;
      logic               mark;
      logic [CODON_W-1:0] codon;
      logic [OUT_W-1:0]   shifts;
      logic [OUT_W-1:0]   trimmed;
      logic               last_word;
   } column_word_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [CODE_W-1:0]   req_ref_base;
   logic [CODE_W-1:0]   req_query_base;
   logic                req_final_column;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CODE_W-1:0]   rsp_out_ref_base;
   logic [CODE_W-1:0]   rsp_out_query_base;
   logic [OUT_W-1:0]    rsp_column_position;
   logic                rsp_is_padding;
   logic                rsp_misaligned_mark;
   logic [CODON_W-1:0]  rsp_misaligned_codon;
   logic [OUT_W-1:0]    rsp_frameshift_count;
   logic [OUT_W-1:0]    rsp_trimmed_length;
   logic                rsp_final_result;
   logic                csr_valid;
   logic                csr_ready;
   logic [CODE_W-1:0]   csr_gap_code;

   // predicted block state
   logic [CODE_W-1:0]   gap_code;
   logic [OUT_W-1:0]    next_position;
   logic [RUN_W-1:0]    ref_run;
   logic [RUN_W-1:0]    query_run;
   logic [RUN_W-1:0]    shift_total;

   column_word_type     expected_words[$];
   column_word_type     got_word;
   column_word_type     want_word;

   int send_idle_pct;
   int recv_idle_pct;
   int columns_sent;
   int words_checked;
   int pads_seen;
   int marks_seen;
   int regions_closed;
   int error_count;
   int quiet_cycles;

   codon_frameshift_gap_padder uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_ref_base(req_ref_base),
      .req_query_base(req_query_base),
      .req_final_column(req_final_column),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_ref_base(rsp_out_ref_base),
      .rsp_out_query_base(rsp_out_query_base),
      .rsp_column_position(rsp_column_position),
      .rsp_is_padding(rsp_is_padding),
      .rsp_misaligned_mark(rsp_misaligned_mark),
      .rsp_misaligned_codon(rsp_misaligned_codon),
      .rsp_frameshift_count(rsp_frameshift_count),
      .rsp_trimmed_length(rsp_trimmed_length),
      .rsp_final_result(rsp_final_result),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_gap_code(csr_gap_code)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] v);
      return (v == SAT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic void clear_region();
      next_position = '0;
      ref_run = '0;
      query_run = '0;
      shift_total = '0;
   endfunction

   function automatic string show_word(input column_word_type w);
      return {$sformatf("ref %0d qry %0d pos %0d pad %0b mark %0b ",
                        w.ref_code, w.query_code, w.position, w.pad, w.mark),
              $sformatf("codon %0d shifts %0d trim %0d last %0b",
                        w.codon, w.shifts, w.trimmed, w.last_word)};
   endfunction

   // works out the padded words one column causes and queues them
   function automatic void pad_column(input logic [CODE_W-1:0] rb, input logic [CODE_W-1:0] qb,
                                      input logic fin);
      logic [OUT_W-1:0]   start_pos;
      logic               mark;
      logic [CODON_W-1:0] codon;
      int                 rmod;
      int                 npad;
      column_word_type    w;
      start_pos = next_position;
      mark = 1'b0;
      codon = '0;
      npad = 0;
      if (rb == gap_code) begin
         ref_run = bump(ref_run);
      end else begin
         rmod = ref_run % CODON_LEN;
         if (qb == gap_code) begin
            query_run = bump(query_run);
         end else if (query_run % CODON_LEN != 0) begin
            // a leading query gap run is dropped without a frameshift
            if (query_run != start_pos)
               shift_total = bump(shift_total);
            query_run = '0;
         end else if (ref_run > 0 && rmod == 0 && start_pos % CODON_LEN != 0) begin
            mark = 1'b1;
         end
         if (rmod != 0 && start_pos % CODON_LEN != rmod)
            mark = 1'b1;
         npad = (rmod != 0) ? CODON_LEN - rmod : 0;
         ref_run = '0;
      end
      if (mark)
         codon = CODON_W'(start_pos / CODON_LEN);
      for (int k = 0; k <= npad; k++) begin
         w.pad = (k < npad);
         w.ref_code = w.pad ? gap_code : rb;
         w.query_code = w.pad ? gap_code : qb;
         w.position = next_position;
         w.mark = mark;
         w.codon = codon;
         w.shifts = shift_total;
         w.trimmed = '0;
         w.last_word = 1'b0;
         next_position = next_position + 1'b1;
         if (fin && k == npad) begin
            w.trimmed = OUT_W'(next_position - (next_position % CODON_LEN));
            w.last_word = 1'b1;
         end
         expected_words = {expected_words, w};
      end
      if (fin)
         clear_region();
   endfunction

   function automatic logic [CODE_W-1:0] any_base();
      logic [CODE_W-1:0] v;
      v = CODE_W'($urandom_range(0, 14));
      if (v >= gap_code)
         v = v + 1'b1;
      return v;
   endfunction

   task automatic send_column(input logic [CODE_W-1:0] rb, input logic [CODE_W-1:0] qb,
                              input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_ref_base <= rb;
      req_query_base <= qb;
      req_final_column <= fin;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pad_column(rb, qb, fin);
      columns_sent++;
   endtask

   task automatic send_kind(input column_kind_type kind, input logic fin);
      logic [CODE_W-1:0] rb;
      logic [CODE_W-1:0] qb;
      rb = (kind == COL_REF_GAP || kind == COL_BOTH_GAP) ? gap_code : any_base();
      qb = (kind == COL_QRY_GAP || kind == COL_BOTH_GAP) ? gap_code : any_base();
      send_column(rb, qb, fin);
   endtask

   // stop sending and let every queued word come out
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gap_code(input logic [CODE_W-1:0] code);
      wait_for_drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_gap_code <= code;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      gap_code = code;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 33;
      recv_idle_pct = 58;
      send_column(4'd0, 4'd0, 1'b0);
      // one reference gap, closed out of frame: two padding words
      send_column(GAP_RESET, 4'd1, 1'b0);
      send_column(4'd2, 4'd3, 1'b0);
      // single query gap then a base: frameshift
      send_column(4'd4, GAP_RESET, 1'b0);
      send_column(4'd14, 4'd14, 1'b0);
      // two reference gaps: one padding word
      send_column(GAP_RESET, 4'd8, 1'b0);
      send_column(GAP_RESET, 4'd9, 1'b0);
      send_column(4'd10, 4'd11, 1'b0);
      // whole-codon reference gap out of frame
      repeat (3) send_column(GAP_RESET, 4'd5, 1'b0);
      send_column(4'd12, 4'd13, 1'b0);
      // whole-codon query run kept, then one more gap makes a frameshift
      repeat (3) send_column(4'd1, GAP_RESET, 1'b0);
      send_column(4'd6, 4'd7, 1'b0);
      send_column(4'd5, GAP_RESET, 1'b0);
      send_column(4'd3, 4'd2, 1'b0);
      // query gap under reference gap, then trailing reference gap at the end
      send_column(GAP_RESET, GAP_RESET, 1'b0);
      send_column(GAP_RESET, 4'd0, 1'b1);
      // leading query gap in a new region
      send_column(4'd5, GAP_RESET, 1'b0);
      send_column(4'd6, 4'd7, 1'b0);
      // padding on the final column
      send_column(GAP_RESET, 4'd4, 1'b0);
      send_column(4'd0, GAP_RESET, 1'b1);
   endtask

   task automatic run_random_phase(input int n_cols, input int sender_pct,
                                   input int receiver_pct);
      int first;
      int pick;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      first = columns_sent;
      while (columns_sent - first < n_cols) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_kind(COL_MATCH, 1'b0);
         end else if (pick < 52) begin
            repeat ($urandom_range(1, 7)) send_kind(COL_REF_GAP, 1'b0);
         end else if (pick < 69) begin
            repeat ($urandom_range(1, 7)) send_kind(COL_QRY_GAP, 1'b0);
         end else if (pick < 74) begin
            repeat ($urandom_range(1, 3)) send_kind(COL_BOTH_GAP, 1'b0);
         end else if (pick < 84) begin
            send_kind(column_kind_type'($urandom_range(0, 3)), 1'b1);
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 3))
               send_column(CODE_W'($urandom_range(0, 15)), CODE_W'($urandom_range(0, 15)),
                           $urandom_range(0, 7) == 0);
         end else begin
            wait_for_drain();
         end
      end
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word = '{rsp_out_ref_base, rsp_out_query_base, rsp_column_position, rsp_is_padding,
                      rsp_misaligned_mark, rsp_misaligned_codon, rsp_frameshift_count,
                      rsp_trimmed_length, rsp_final_result};
         words_checked++;
         pads_seen += rsp_is_padding;
         marks_seen += rsp_misaligned_mark;
         regions_closed += rsp_final_result;
         if (expected_words.size() == 0) begin
            error_count++;
            if (error_count <= SHOW_LIMIT)
               $display("unexpected word at position %0d", rsp_column_position);
         end else begin
            want_word = expected_words.pop_front();
            if (got_word !== want_word) begin
               error_count++;
               if (error_count <= SHOW_LIMIT) begin
                  $display("mismatch word %0d expected: %s", words_checked,
                           show_word(want_word));
                  $display("mismatch word %0d actual:   %s", words_checked,
                           show_word(got_word));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("codon_frameshift_gap_padder_test: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_ref_base = '0;
      req_query_base = '0;
      req_final_column = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_gap_code = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      columns_sent = 0;
      words_checked = 0;
      pads_seen = 0;
      marks_seen = 0;
      regions_closed = 0;
      error_count = 0;
      quiet_cycles = 0;
      gap_code = GAP_RESET;
      clear_region();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      write_gap_code(4'd0);
      run_random_phase(95, 33, 58);
      write_gap_code(CODE_W'($urandom_range(1, 14)));
      run_random_phase(95, 58, 33);
      write_gap_code(4'd7);
      run_random_phase(95, 0, 0);
      wait_for_drain();

      if (expected_words.size() != 0)
         error_count++;
      $display("sent %0d columns, checked %0d words (%0d padding, %0d marked, %0d regions)",
               columns_sent, words_checked, pads_seen, marks_seen, regions_closed);
      $display("gap codes 15, 0, mid-range and 7 used; directed padding and frameshift cases run");
      if (error_count == 0)
         $display("codon_frameshift_gap_padder_test: clean");
      else
         $display("codon_frameshift_gap_padder_test: errors");
      $finish;
   end

endmodule
